/* sv/calendar_second_counter_unit_macros.svh */
// Assertion macros for the calendar counter RTL.
`ifndef CALENDAR_SECOND_COUNTER_UNIT_MACROS_SVH
`define CALENDAR_SECOND_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSCU_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSCU_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cscu_pkg.sv */
// Types, constants and helper functions for the calendar second counter.
`timescale 1ns / 1ps
`default_nettype none
package cscu_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    LVL_SECOND = 2'd0,
    LVL_MINUTE = 2'd1,
    LVL_DATE   = 2'd2,
    LVL_LOAD   = 2'd3
  } level_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } in_item_t;

  typedef struct packed {
    logic [11:0] year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    level_t      change_level;
  } out_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  localparam logic [11:0] YEAR_RESET  = 12'd1900;
  localparam logic [3:0]  MONTH_RESET = 4'd1;
  localparam logic [4:0]  DAY_RESET   = 5'd1;

  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // y * RECIP25 = q * (2^17 + 3) + r * RECIP25 for y = 25q + r; the low 17
  // bits stay under DIV25_LIMIT exactly when r is zero (12-bit y).
  localparam logic [12:0] RECIP25     = 13'd5243;
  localparam logic [16:0] DIV25_LIMIT = 17'd4096;

  function automatic logic is_leap(input logic [11:0] y);
    logic [24:0] prod;
    logic        div25;
    prod  = 25'(y) * 25'(RECIP25);
    div25 = (prod[16:0] < DIV25_LIMIT);
    // multiple of 4; on a century (4 and 25) it must also divide by 16
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
      MONTH_FEB: d = leap ? 5'd29 : 5'd28;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* sv/cscu_next.sv */
// Next calendar value and change level for one item.
`timescale 1ns / 1ps
`default_nettype none
module cscu_next (
  input  cscu_pkg::cal_t     cal,
  input  cscu_pkg::in_item_t item,
  output cscu_pkg::cal_t     cal_nxt,
  output cscu_pkg::level_t   level
);
  import cscu_pkg::*;

  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       leap;
  logic [5:0] day_inc;
  logic       day_over;
  logic       year_wrap;

  assign sec_wrap  = (cal.second >= SEC_LAST);
  assign min_wrap  = (cal.minute >= MIN_LAST);
  assign hour_wrap = (cal.hour >= HOUR_LAST);
  assign leap      = is_leap(cal.year);
  assign day_inc   = 6'(cal.day) + 6'd1;
  assign day_over  = (day_inc > 6'(month_days(cal.month, leap)));
  assign year_wrap = (cal.month >= MONTH_DEC);

  always_comb begin
    cal_nxt = cal;
    level   = LVL_SECOND;
    if (item.op == OP_LOAD) begin
      cal_nxt.year   = item.set_year;
      cal_nxt.month  = item.set_month;
      cal_nxt.day    = item.set_day;
      cal_nxt.hour   = item.set_hour;
      cal_nxt.minute = item.set_minute;
      cal_nxt.second = item.set_second;
      level          = LVL_LOAD;
    end else if (!sec_wrap) begin
      cal_nxt.second = cal.second + 6'd1;
    end else begin
      cal_nxt.second = '0;
      level          = LVL_MINUTE;
      if (!min_wrap) begin
        cal_nxt.minute = cal.minute + 6'd1;
      end else begin
        cal_nxt.minute = '0;
        if (!hour_wrap) begin
          cal_nxt.hour = cal.hour + 5'd1;
        end else begin
          cal_nxt.hour = '0;
          level        = LVL_DATE;
          if (day_over) begin
            cal_nxt.day = DAY_RESET;
            if (year_wrap) begin
              cal_nxt.month = MONTH_JAN;
              cal_nxt.year  = cal.year + 12'd1;
            end else begin
              cal_nxt.month = cal.month + 4'd1;
            end
          end else begin
            cal_nxt.day = day_inc[4:0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/calendar_second_counter_unit.sv */
// Top level of the calendar second counter: input stage, calendar state, result stage.
// Pipeline: an accepted item enters the input register, then moves to the result
//   register once that is free; out_stall on a waiting result holds it there.
// Throughput: one item per cycle while out_stall stays low; in_stall follows
//   out_stall combinationally, and the carry chain plus leap test are combinational.
// Reset (rst_n low, synchronous): both stages empty, calendar 1900-01-01 00:00:00.
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_second_counter_unit_macros.svh"
module calendar_second_counter_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cscu_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cscu_pkg::out_item_t  out_data
);
  import cscu_pkg::*;

  // Input stage
  logic     s1_valid_r;
  in_item_t s1_item_r;

  // Calendar state, updated when the item in the input stage moves on
  cal_t   cal_r;
  cal_t   cal_nxt;
  level_t level_nxt;

  // Result stage
  logic      out_valid_r;
  out_item_t out_r;

  logic s1_adv;   // result register free this cycle
  logic s1_fire;  // an item moves from the input stage to the result

  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  cscu_next u_next (
    .cal     (cal_r),
    .item    (s1_item_r),
    .cal_nxt (cal_nxt),
    .level   (level_nxt)
  );

  // Calendar registers: the next item sees this one's update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.year   <= YEAR_RESET;
      cal_r.month  <= MONTH_RESET;
      cal_r.day    <= DAY_RESET;
      cal_r.hour   <= '0;
      cal_r.minute <= '0;
      cal_r.second <= '0;
    end else if (s1_fire) begin
      cal_r <= cal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r.year_now     <= cal_nxt.year;
      out_r.month_now    <= cal_nxt.month;
      out_r.day_now      <= cal_nxt.day;
      out_r.hour_now     <= cal_nxt.hour;
      out_r.minute_now   <= cal_nxt.minute;
      out_r.second_now   <= cal_nxt.second;
      out_r.change_level <= level_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A held result always mirrors the live calendar (no item slips past it)
  `CSCU_ASSERT_NOW(a_out_matches_cal, clk, rst_n, out_valid_r,
    (out_r.year_now == cal_r.year) && (out_r.month_now == cal_r.month) &&
    (out_r.day_now == cal_r.day) && (out_r.hour_now == cal_r.hour) &&
    (out_r.minute_now == cal_r.minute) && (out_r.second_now == cal_r.second),
    "result register out of step with calendar state")

  // Plain tick never leaves seconds at zero
  `CSCU_ASSERT_NOW(a_tick_sec_nonzero, clk, rst_n,
    out_valid_r && (out_r.change_level == LVL_SECOND),
    out_r.second_now != 6'd0, "second-only change with second at zero")

  // Date change means the whole time of day rolled over
  `CSCU_ASSERT_NOW(a_date_midnight, clk, rst_n,
    out_valid_r && (out_r.change_level == LVL_DATE),
    (out_r.second_now == 6'd0) && (out_r.minute_now == 6'd0) && (out_r.hour_now == 5'd0),
    "date change without midnight")

  // An item leaving the input stage shows up in the result register
  `CSCU_ASSERT_NEXT(a_fire_to_out, clk, rst_n, s1_fire, out_valid_r,
    "item lost between input stage and result")

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the calendar second counter: directed corners, then random load/tick runs.
`timescale 1ns / 1ps
module tb;
  import cscu_pkg::*;

  // Watchdog: cycles with no handshake on either channel before giving up.
  // The longest legal quiet stretch is the output hold below plus a long gap.
  localparam int WATCHDOG_LIMIT = 1000;
  // Length of the deliberate output hold that backs the pipe up.
  localparam int HOLD_CYCLES    = 80;
  // Target number of input items in the random part.
  localparam int RANDOM_ITEMS   = 600;
  // Settle time after the last result.
  localparam int DRAIN_CYCLES   = 20;

  // Calendar model plus the queue of results still owed by the block.
  class calendar_scoreboard;
    cal_t      now;
    out_item_t pending_q[$];
    int        errors;
    int        checked;
    int        loads;
    int        date_changes;

    function new();
      now.year   = YEAR_RESET;
      now.month  = MONTH_RESET;
      now.day    = DAY_RESET;
      now.hour   = '0;
      now.minute = '0;
      now.second = '0;
    endfunction

    // Gregorian rule on the full year; year 0 divides by 400.
    function bit leap_year(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Any month code outside 1..12 counts as a 31-day month.
    function int month_length(int m, int y);
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) return 30;
      if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
      return 31;
    endfunction

    // Advance the model by one accepted item and queue the result it owes.
    function void note_input(in_item_t it);
      out_item_t res;
      int        next_day;
      res.change_level = LVL_SECOND;
      if (it.op == OP_LOAD) begin
        // stored as given, range or not
        now.year   = it.set_year;
        now.month  = it.set_month;
        now.day    = it.set_day;
        now.hour   = it.set_hour;
        now.minute = it.set_minute;
        now.second = it.set_second;
        res.change_level = LVL_LOAD;
        loads++;
      end else if (now.second < SEC_LAST) begin
        now.second++;
      end else begin
        // at or past 59 wraps; minute likewise, hour at or past 23
        now.second = '0;
        res.change_level = LVL_MINUTE;
        if (now.minute < MIN_LAST) begin
          now.minute++;
        end else begin
          now.minute = '0;
          if (now.hour < HOUR_LAST) begin
            now.hour++;
          end else begin
            now.hour = '0;
            res.change_level = LVL_DATE;
            next_day = int'(now.day) + 1;
            if (next_day > month_length(int'(now.month), int'(now.year))) begin
              now.day = 5'd1;
              if (now.month >= MONTH_DEC) begin
                now.month = MONTH_JAN;
                now.year  = now.year + 12'd1;   // 4095 wraps to 0
              end else begin
                now.month++;                    // month 0 goes to 1
              end
            end else begin
              now.day = 5'(next_day);
            end
          end
        end
      end
      res.year_now   = now.year;
      res.month_now  = now.month;
      res.day_now    = now.day;
      res.hour_now   = now.hour;
      res.minute_now = now.minute;
      res.second_now = now.second;
      pending_q.push_back(res);
    endfunction

    function void cmp(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one accepted result against the oldest owed result.
    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: %p", got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (exp_r.change_level == LVL_DATE) date_changes++;
      cmp("year_now",     exp_r.year_now,     got.year_now);
      cmp("month_now",    exp_r.month_now,    got.month_now);
      cmp("day_now",      exp_r.day_now,      got.day_now);
      cmp("hour_now",     exp_r.hour_now,     got.hour_now);
      cmp("minute_now",   exp_r.minute_now,   got.minute_now);
      cmp("second_now",   exp_r.second_now,   got.second_now);
      cmp("change_level", exp_r.change_level, got.change_level);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  calendar_scoreboard sb = new();

  // Flags shared between the stimulus and the receiver process, and run counters.
  bit no_idle      = 1'b0;   // both sides run flat out while set
  bit hold_request = 1'b0;   // asks the receiver for one long hold
  bit hold_done    = 1'b0;
  int sent         = 0;
  int idle_cycles  = 0;

  calendar_second_counter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Tick with junk in the set fields; the block has to ignore them.
  function automatic in_item_t tick_item();
    in_item_t it;
    it    = in_item_t'({$urandom, $urandom});
    it.op = OP_TICK;
    return it;
  endfunction

  // Load with every field fully random, out-of-range codes included.
  function automatic in_item_t noise_load();
    in_item_t it;
    it    = in_item_t'({$urandom, $urandom});
    it.op = OP_LOAD;
    return it;
  endfunction

  // Load just short of a carry: end of day, end of month, century years.
  function automatic in_item_t boundary_load();
    in_item_t it;
    int       y;
    it    = '0;
    it.op = OP_LOAD;
    case ($urandom_range(0, 4))
      0:       y = $urandom_range(0, 4095);
      1:       y = 100 * $urandom_range(0, 40);
      2:       y = 400 * $urandom_range(0, 10);
      3:       y = 4 * $urandom_range(0, 1023);
      default: y = $urandom_range(0, 1) ? 4095 : 0;
    endcase
    it.set_year  = 12'(y);
    it.set_month = 4'($urandom_range(1, 12));
    case ($urandom_range(0, 3))
      0:       it.set_day = 5'd28;
      1:       it.set_day = 5'd29;
      2:       it.set_day = $urandom_range(0, 1) ? 5'd30 : 5'd31;
      default: it.set_day = 5'($urandom_range(1, 31));
    endcase
    it.set_hour   = ($urandom_range(0, 3) != 0) ? HOUR_LAST : 5'($urandom_range(0, 23));
    it.set_minute = ($urandom_range(0, 3) != 0) ? MIN_LAST : 6'($urandom_range(0, 59));
    it.set_second = 6'($urandom_range(50, 59));
    return it;
  endfunction

  // Offer one item and hold it until the block takes it. Valid stays high
  // straight into the next item when there is no gap.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Load a calendar, then tick once across the carry it sets up.
  task automatic load_tick(input int y, input int m, input int d,
                           input int h, input int mi, input int s);
    in_item_t it;
    it            = '0;
    it.op         = OP_LOAD;
    it.set_year   = 12'(y);
    it.set_month  = 4'(m);
    it.set_day    = 5'(d);
    it.set_hour   = 5'(h);
    it.set_minute = 6'(mi);
    it.set_second = 6'(s);
    send_item(it);
    send_item(tick_item());
  endtask

  // Receiver: random stall gaps, free-running stretches, and one long hold
  // on request while the sender keeps offering items.
  initial begin
    int gap;
    repeat (7) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Monitor: both channels sampled on the edge, before the block updates.
  // Also the watchdog: any handshake resets the quiet count.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake, %0d results pending",
                 WATCHDOG_LIMIT, sb.pending());
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners. First tick straight out of reset.
    send_item(tick_item());
    load_tick(1900,  2, 28, 23, 59, 59);   // century, not leap: goes to March
    load_tick(2000,  2, 28, 23, 59, 59);   // divides by 400: Feb 29
    load_tick(2024,  2, 29, 23, 59, 59);   // leap day rolls to March
    load_tick(4095, 12, 31, 23, 59, 59);   // year wraps to 0
    load_tick(0,     2, 28, 23, 59, 59);   // year 0 is leap
    load_tick(2023,  4, 30, 23, 59, 59);   // 30-day month
    load_tick(2023,  1, 31, 23, 59, 59);   // day 31 must advance the month
    load_tick(2023,  0, 31, 23, 59, 59);   // month 0 counts 31 days, goes to 1
    load_tick(2023, 13, 31, 23, 59, 59);   // month past 12 rolls the year
    load_tick(4095, 15, 31, 31, 63, 63);   // every field at its widest
    load_tick(0,     0,  0,  0,  0,  0);   // every field zero
    load_tick(2023,  6, 15, 10, 30, 59);   // minute carry only

    // Random part: mostly a boundary load followed by a run of ticks,
    // some noise loads, some bare tick runs.
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 99) < 15);
      if (sent >= 200 && !hold_request) begin
        hold_request = 1'b1;
        no_idle      = 1'b1;   // keep offering so the pipe fills and stalls
      end
      r = $urandom_range(0, 99);
      if (r < 80) send_item(boundary_load());
      else if (r < 92) send_item(noise_load());
      repeat ($urandom_range(1, 12)) send_item(tick_item());
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // Drain; the watchdog covers a block that never finishes.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items sent, %0d loads, %0d results checked",
             sent, sb.loads, sb.checked);
    $display("run: %0d date rollovers, one %0d-cycle output hold under load",
             sb.date_changes, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
